### rtl/core/sbms_pkg.sv
`default_nettype none

package sbms_pkg;

   // Sequencer states, one-hot.
   typedef enum logic [13:0] {
      ST_BOOT         = 14'b00000000000001,
      ST_WIFI         = 14'b00000000000010,
      ST_NEEDS_HOMING = 14'b00000000000100,
      ST_HOMING       = 14'b00000000001000,
      ST_IDLE         = 14'b00000000010000,
      ST_UNLOCKING    = 14'b00000000100000,
      ST_MOVING       = 14'b00000001000000,
      ST_SETTLING     = 14'b00000010000000,
      ST_LOCKING      = 14'b00000100000000,
      ST_LOCKED       = 14'b00001000000000,
      ST_DUST         = 14'b00010000000000,
      ST_CUTTING      = 14'b00100000000000,
      ST_ERROR        = 14'b01000000000000,
      ST_ESTOP        = 14'b10000000000000
   } state_type;

   // Event codes.
   localparam logic [3:0] MODE_TICK        = 4'd0;
   localparam logic [3:0] MODE_HOME        = 4'd1;
   localparam logic [3:0] MODE_GOTO        = 4'd2;
   localparam logic [3:0] MODE_LOCK        = 4'd3;
   localparam logic [3:0] MODE_UNLOCK      = 4'd4;
   localparam logic [3:0] MODE_ESTOP       = 4'd5;
   localparam logic [3:0] MODE_RESET       = 4'd6;
   localparam logic [3:0] MODE_START_CUT   = 4'd7;
   localparam logic [3:0] MODE_END_CUT     = 4'd8;
   localparam logic [3:0] MODE_JOG         = 4'd9;
   localparam logic [3:0] MODE_NEXT_CUT    = 4'd10;
   localparam logic [3:0] MODE_LOCK_TOGGLE = 4'd11;

   // Register indexes.
   localparam logic [2:0] CSR_MAX_TRAVEL    = 3'd0;
   localparam logic [2:0] CSR_POS_TOL       = 3'd1;
   localparam logic [2:0] CSR_MOVE_TIMEOUT  = 3'd2;
   localparam logic [2:0] CSR_SETTLE_TIMEOUT = 3'd3;
   localparam logic [2:0] CSR_WIFI_TIMEOUT  = 3'd4;
   localparam logic [2:0] CSR_AP_FALLBACK   = 3'd5;

   // Subsystem command codes.
   localparam logic [2:0] STEP_NONE  = 3'd0;
   localparam logic [2:0] STEP_HOME  = 3'd1;
   localparam logic [2:0] STEP_MOVE  = 3'd2;
   localparam logic [2:0] STEP_JOG   = 3'd3;
   localparam logic [2:0] STEP_STOP  = 3'd4;
   localparam logic [2:0] STEP_ESTOP = 3'd5;

   localparam logic [1:0] LATCH_NONE   = 2'd0;
   localparam logic [1:0] LATCH_LOCK   = 2'd1;
   localparam logic [1:0] LATCH_UNLOCK = 2'd2;

   localparam logic [1:0] DUST_NONE  = 2'd0;
   localparam logic [1:0] DUST_ON    = 2'd1;
   localparam logic [1:0] DUST_OFF   = 2'd2;
   localparam logic [1:0] DUST_FORCE = 2'd3;

   localparam logic [1:0] CLAMP_NONE    = 2'd0;
   localparam logic [1:0] CLAMP_ENGAGE  = 2'd1;
   localparam logic [1:0] CLAMP_RELEASE = 2'd2;

   localparam logic [1:0] WIFI_NONE    = 2'd0;
   localparam logic [1:0] WIFI_STATION = 2'd1;
   localparam logic [1:0] WIFI_AP      = 2'd2;

   localparam logic [1:0] PHASE_RUNNING = 2'd0;
   localparam logic [1:0] PHASE_DONE    = 2'd1;
   localparam logic [1:0] PHASE_FAIL    = 2'd2;

   localparam logic [1:0] LSTAT_TRANSIT  = 2'd0;
   localparam logic [1:0] LSTAT_LOCKED   = 2'd1;
   localparam logic [1:0] LSTAT_UNLOCKED = 2'd2;

   localparam logic [2:0] ERR_NONE    = 3'd0;
   localparam logic [2:0] ERR_FAR     = 3'd1;
   localparam logic [2:0] ERR_HOMING  = 3'd2;
   localparam logic [2:0] ERR_TIMEOUT = 3'd3;
   localparam logic [2:0] ERR_POS     = 3'd4;

   localparam logic [2:0] LIGHT_CHASE_WHITE  = 3'd0;
   localparam logic [2:0] LIGHT_PULSE_YELLOW = 3'd1;
   localparam logic [2:0] LIGHT_BLUE         = 3'd2;
   localparam logic [2:0] LIGHT_GREEN        = 3'd3;
   localparam logic [2:0] LIGHT_PULSE_GREEN  = 3'd4;
   localparam logic [2:0] LIGHT_ORANGE       = 3'd5;
   localparam logic [2:0] LIGHT_RED          = 3'd6;
   localparam logic [2:0] LIGHT_FLASH_RED    = 3'd7;

   localparam logic [23:0] TICK_MAX = 24'hFFFFFF;

   typedef struct packed {
      logic [19:0] max_travel;
      logic [15:0] position_tolerance;
      logic [23:0] move_timeout_ticks;
      logic [23:0] settling_timeout_ticks;
      logic [23:0] wifi_timeout_ticks;
      logic        ap_fallback_enable;
   } cfg_type;

   typedef struct packed {
      logic [3:0]         mode;
      logic signed [20:0] motion_value;
      logic               cut_available;
      logic               tool_present;
      logic [15:0]        kerf;
      logic               stepper_moving;
      logic               far_switch;
      logic [1:0]         homing_phase;
      logic [1:0]         latch_status;
      logic               dust_spun_up;
      logic               wifi_connected;
      logic signed [20:0] dro_position;
   } item_type;

   typedef struct packed {
      state_type   fsm_state;
      logic [19:0] target_reg;
      logic [23:0] ticks_in_state;
      logic        wifi_started;
      logic [2:0]  last_error;
   } ctx_type;

   typedef struct packed {
      logic [3:0]         fsm_state_out;
      logic [2:0]         light_pattern;
      logic [2:0]         stepper_cmd;
      logic signed [20:0] stepper_value;
      logic [1:0]         latch_cmd;
      logic [1:0]         dust_cmd;
      logic [1:0]         clamp_cmd;
      logic [1:0]         wifi_cmd;
      logic               mark_cut_done;
      logic [2:0]         error_code;
      logic [19:0]        target_position;
   } result_type;

   function automatic logic [3:0] state_code(state_type s);
      logic [3:0] c;
      case (s)
         ST_BOOT:         c = 4'd0;
         ST_WIFI:         c = 4'd1;
         ST_NEEDS_HOMING: c = 4'd2;
         ST_HOMING:       c = 4'd3;
         ST_IDLE:         c = 4'd4;
         ST_UNLOCKING:    c = 4'd5;
         ST_MOVING:       c = 4'd6;
         ST_SETTLING:     c = 4'd7;
         ST_LOCKING:      c = 4'd8;
         ST_LOCKED:       c = 4'd9;
         ST_DUST:         c = 4'd10;
         ST_CUTTING:      c = 4'd11;
         ST_ERROR:        c = 4'd12;
         ST_ESTOP:        c = 4'd13;
         default:         c = 4'd0;
      endcase
      return c;
   endfunction

   function automatic logic [2:0] state_light(state_type s);
      logic [2:0] l;
      case (s)
         ST_NEEDS_HOMING, ST_MOVING:             l = LIGHT_PULSE_YELLOW;
         ST_HOMING:                              l = LIGHT_BLUE;
         ST_IDLE, ST_LOCKED:                     l = LIGHT_GREEN;
         ST_UNLOCKING, ST_SETTLING, ST_LOCKING:  l = LIGHT_PULSE_GREEN;
         ST_DUST, ST_CUTTING:                    l = LIGHT_ORANGE;
         ST_ERROR:                               l = LIGHT_RED;
         ST_ESTOP:                               l = LIGHT_FLASH_RED;
         default:                                l = LIGHT_CHASE_WHITE;
      endcase
      return l;
   endfunction

endpackage

`default_nettype wire

### rtl/core/sbms_csr.sv
`default_nettype none

module sbms_csr (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_we,
   input  wire logic [2:0]       csr_index,
   input  wire logic [23:0]      csr_wdata,
   output sbms_pkg::cfg_type     cfg
);

   sbms_pkg::cfg_type cfg_ff;
   sbms_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            sbms_pkg::CSR_MAX_TRAVEL:     cfg_in.max_travel = csr_wdata[19:0];
            sbms_pkg::CSR_POS_TOL:        cfg_in.position_tolerance = csr_wdata[15:0];
            sbms_pkg::CSR_MOVE_TIMEOUT:   cfg_in.move_timeout_ticks = csr_wdata;
            sbms_pkg::CSR_SETTLE_TIMEOUT: cfg_in.settling_timeout_ticks = csr_wdata;
            sbms_pkg::CSR_WIFI_TIMEOUT:   cfg_in.wifi_timeout_ticks = csr_wdata;
            sbms_pkg::CSR_AP_FALLBACK:    cfg_in.ap_fallback_enable = csr_wdata[0];
            default: ;  // drop writes past the last register
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_travel             <= 20'd120000;
         cfg_ff.position_tolerance     <= 16'd5;
         cfg_ff.move_timeout_ticks     <= 24'd30000;
         cfg_ff.settling_timeout_ticks <= 24'd2000;
         cfg_ff.wifi_timeout_ticks     <= 24'd10000;
         cfg_ff.ap_fallback_enable     <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### rtl/core/sbms_step.sv
`default_nettype none

module sbms_step (
   input  wire sbms_pkg::ctx_type    cur,
   input  wire sbms_pkg::cfg_type    cfg,
   input  wire sbms_pkg::item_type   item,
   output sbms_pkg::ctx_type         nxt,
   output sbms_pkg::result_type      rsp
);

   logic [23:0]        ticks_inc;
   logic signed [21:0] goto_t;
   logic               goto_range_ok;
   logic               goto_state_ok;
   logic signed [21:0] diff;
   logic [20:0]        diff_mag;
   logic               in_window;
   logic               do_goto;

   always_comb begin
      ticks_inc = (cur.ticks_in_state == sbms_pkg::TICK_MAX) ?
                  cur.ticks_in_state : cur.ticks_in_state + 24'd1;

      // Next cut adds the kerf of a detected tool to the cut length.
      goto_t = 22'(item.motion_value);
      if (item.mode == sbms_pkg::MODE_NEXT_CUT && item.tool_present)
         goto_t = 22'(item.motion_value) + $signed({6'd0, item.kerf});
      goto_range_ok = !goto_t[21] && (goto_t[20:0] <= {1'b0, cfg.max_travel});
      goto_state_ok = (cur.fsm_state == sbms_pkg::ST_IDLE) ||
                      (cur.fsm_state == sbms_pkg::ST_LOCKED);

      diff     = 22'(item.dro_position) - $signed({2'b00, cur.target_reg});
      diff_mag = diff[21] ? 21'(-diff) : diff[20:0];
      in_window = diff_mag <= {5'd0, cfg.position_tolerance};
   end

   always_comb begin
      nxt = cur;
      do_goto = 1'b0;
      rsp.stepper_cmd   = sbms_pkg::STEP_NONE;
      rsp.stepper_value = '0;
      rsp.latch_cmd     = sbms_pkg::LATCH_NONE;
      rsp.dust_cmd      = sbms_pkg::DUST_NONE;
      rsp.clamp_cmd     = sbms_pkg::CLAMP_NONE;
      rsp.wifi_cmd      = sbms_pkg::WIFI_NONE;
      rsp.mark_cut_done = 1'b0;

      case (item.mode)
         sbms_pkg::MODE_TICK: begin
            nxt.ticks_in_state = ticks_inc;
            case (cur.fsm_state)
               sbms_pkg::ST_WIFI: begin
                  if (!cur.wifi_started) begin
                     rsp.wifi_cmd = sbms_pkg::WIFI_STATION;
                     nxt.wifi_started = 1'b1;
                  end
                  if (item.wifi_connected) begin
                     nxt.wifi_started   = 1'b0;
                     nxt.fsm_state      = sbms_pkg::ST_NEEDS_HOMING;
                     nxt.ticks_in_state = '0;
                  end else if (ticks_inc > cfg.wifi_timeout_ticks &&
                               cfg.ap_fallback_enable) begin
                     rsp.wifi_cmd       = sbms_pkg::WIFI_AP;
                     nxt.wifi_started   = 1'b0;
                     nxt.fsm_state      = sbms_pkg::ST_NEEDS_HOMING;
                     nxt.ticks_in_state = '0;
                  end
               end
               sbms_pkg::ST_HOMING: begin
                  if (item.homing_phase == sbms_pkg::PHASE_DONE) begin
                     nxt.fsm_state      = sbms_pkg::ST_IDLE;
                     nxt.ticks_in_state = '0;
                  end else if (item.homing_phase == sbms_pkg::PHASE_FAIL) begin
                     nxt.last_error     = sbms_pkg::ERR_HOMING;
                     nxt.fsm_state      = sbms_pkg::ST_ERROR;
                     nxt.ticks_in_state = '0;
                  end
               end
               sbms_pkg::ST_UNLOCKING: begin
                  if (item.latch_status == sbms_pkg::LSTAT_UNLOCKED) begin
                     nxt.ticks_in_state = '0;
                     if (cur.target_reg == '0) begin
                        nxt.fsm_state     = sbms_pkg::ST_IDLE;
                     end else if (item.far_switch) begin
                        // Far limit already active as the move starts: stop at once.
                        rsp.stepper_cmd   = sbms_pkg::STEP_STOP;
                        nxt.last_error    = sbms_pkg::ERR_FAR;
                        nxt.fsm_state     = sbms_pkg::ST_ERROR;
                     end else begin
                        rsp.stepper_cmd   = sbms_pkg::STEP_MOVE;
                        rsp.stepper_value = $signed({1'b0, cur.target_reg});
                        nxt.fsm_state     = sbms_pkg::ST_MOVING;
                     end
                  end
               end
               sbms_pkg::ST_MOVING: begin
                  // Stop, timeout and far limit, in that priority.
                  if (!item.stepper_moving) begin
                     nxt.fsm_state      = sbms_pkg::ST_SETTLING;
                     nxt.ticks_in_state = '0;
                  end else if (ticks_inc > cfg.move_timeout_ticks) begin
                     rsp.stepper_cmd    = sbms_pkg::STEP_STOP;
                     nxt.last_error     = sbms_pkg::ERR_TIMEOUT;
                     nxt.fsm_state      = sbms_pkg::ST_ERROR;
                     nxt.ticks_in_state = '0;
                  end else if (item.far_switch) begin
                     rsp.stepper_cmd    = sbms_pkg::STEP_STOP;
                     nxt.last_error     = sbms_pkg::ERR_FAR;
                     nxt.fsm_state      = sbms_pkg::ST_ERROR;
                     nxt.ticks_in_state = '0;
                  end
               end
               sbms_pkg::ST_SETTLING: begin
                  if (in_window) begin
                     rsp.latch_cmd      = sbms_pkg::LATCH_LOCK;
                     nxt.fsm_state      = sbms_pkg::ST_LOCKING;
                     nxt.ticks_in_state = '0;
                  end else if (ticks_inc > cfg.settling_timeout_ticks) begin
                     nxt.last_error     = sbms_pkg::ERR_POS;
                     nxt.fsm_state      = sbms_pkg::ST_ERROR;
                     nxt.ticks_in_state = '0;
                  end
               end
               sbms_pkg::ST_LOCKING: begin
                  if (item.latch_status == sbms_pkg::LSTAT_LOCKED) begin
                     nxt.fsm_state      = sbms_pkg::ST_LOCKED;
                     nxt.ticks_in_state = '0;
                  end
               end
               sbms_pkg::ST_DUST: begin
                  if (item.dust_spun_up) begin
                     nxt.fsm_state      = sbms_pkg::ST_CUTTING;
                     nxt.ticks_in_state = '0;
                  end
               end
               default: ;
            endcase
         end
         sbms_pkg::MODE_HOME: begin
            if (cur.fsm_state == sbms_pkg::ST_NEEDS_HOMING ||
                cur.fsm_state == sbms_pkg::ST_IDLE) begin
               rsp.stepper_cmd    = sbms_pkg::STEP_HOME;
               nxt.fsm_state      = sbms_pkg::ST_HOMING;
               nxt.ticks_in_state = '0;
            end
         end
         sbms_pkg::MODE_GOTO: begin
            do_goto = goto_state_ok && goto_range_ok;
         end
         sbms_pkg::MODE_NEXT_CUT: begin
            do_goto = goto_state_ok && item.cut_available && goto_range_ok;
         end
         sbms_pkg::MODE_LOCK, sbms_pkg::MODE_UNLOCK, sbms_pkg::MODE_LOCK_TOGGLE: begin
            if (cur.fsm_state == sbms_pkg::ST_IDLE &&
                item.mode != sbms_pkg::MODE_UNLOCK) begin
               rsp.latch_cmd      = sbms_pkg::LATCH_LOCK;
               nxt.fsm_state      = sbms_pkg::ST_LOCKING;
               nxt.ticks_in_state = '0;
            end else if (cur.fsm_state == sbms_pkg::ST_LOCKED &&
                         item.mode != sbms_pkg::MODE_LOCK) begin
               rsp.latch_cmd      = sbms_pkg::LATCH_UNLOCK;
               rsp.clamp_cmd      = sbms_pkg::CLAMP_RELEASE;
               nxt.fsm_state      = sbms_pkg::ST_UNLOCKING;
               nxt.ticks_in_state = '0;
            end
         end
         sbms_pkg::MODE_ESTOP: begin
            rsp.stepper_cmd    = sbms_pkg::STEP_ESTOP;
            rsp.dust_cmd       = sbms_pkg::DUST_FORCE;
            rsp.clamp_cmd      = sbms_pkg::CLAMP_RELEASE;
            nxt.fsm_state      = sbms_pkg::ST_ESTOP;
            nxt.ticks_in_state = '0;
         end
         sbms_pkg::MODE_RESET: begin
            if (cur.fsm_state == sbms_pkg::ST_ERROR ||
                cur.fsm_state == sbms_pkg::ST_ESTOP) begin
               nxt.last_error     = sbms_pkg::ERR_NONE;
               nxt.fsm_state      = sbms_pkg::ST_NEEDS_HOMING;
               nxt.ticks_in_state = '0;
            end
         end
         sbms_pkg::MODE_START_CUT: begin
            if (cur.fsm_state == sbms_pkg::ST_LOCKED) begin
               rsp.dust_cmd       = sbms_pkg::DUST_ON;
               rsp.clamp_cmd      = sbms_pkg::CLAMP_ENGAGE;
               nxt.fsm_state      = sbms_pkg::ST_DUST;
               nxt.ticks_in_state = '0;
            end
         end
         sbms_pkg::MODE_END_CUT: begin
            if (cur.fsm_state == sbms_pkg::ST_CUTTING) begin
               rsp.dust_cmd       = sbms_pkg::DUST_OFF;
               rsp.clamp_cmd      = sbms_pkg::CLAMP_RELEASE;
               rsp.mark_cut_done  = item.cut_available;
               nxt.fsm_state      = sbms_pkg::ST_LOCKED;
               nxt.ticks_in_state = '0;
            end
         end
         sbms_pkg::MODE_JOG: begin
            if (cur.fsm_state == sbms_pkg::ST_IDLE) begin
               rsp.stepper_cmd    = sbms_pkg::STEP_JOG;
               rsp.stepper_value  = item.motion_value;
               nxt.fsm_state      = sbms_pkg::ST_MOVING;
               nxt.ticks_in_state = '0;
            end
         end
         default: ;
      endcase

      // Shared go-to action: unlock first when locked, else start the move.
      if (do_goto) begin
         nxt.target_reg     = goto_t[19:0];
         nxt.ticks_in_state = '0;
         if (cur.fsm_state == sbms_pkg::ST_LOCKED) begin
            rsp.latch_cmd = sbms_pkg::LATCH_UNLOCK;
            nxt.fsm_state = sbms_pkg::ST_UNLOCKING;
         end else begin
            rsp.stepper_cmd   = sbms_pkg::STEP_MOVE;
            rsp.stepper_value = $signed({1'b0, goto_t[19:0]});
            nxt.fsm_state     = sbms_pkg::ST_MOVING;
         end
      end

      rsp.fsm_state_out   = sbms_pkg::state_code(nxt.fsm_state);
      rsp.light_pattern   = sbms_pkg::state_light(nxt.fsm_state);
      rsp.error_code      = nxt.last_error;
      rsp.target_position = nxt.target_reg;
   end

endmodule

`default_nettype wire

### rtl/core/stop_block_motion_sequencer.sv
// Motion sequencer for a motorized stop block.
// Request channel (req_): one event word per item. req_tuser carries the
// event code (tick or command); req_tdata carries the motion value and the
// subsystem status, which is read only on ticks.
// Response channel (rsp_): exactly one word per event with the new state,
// light pattern, subsystem commands, cut-done pulse, latched error code and
// stored target.
// Configuration: csr_we writes csr_wdata into register csr_index in the
// same edge; indexes past the last register are ignored. Write only while
// no event is in flight.
// Pipeline: an event taken is held in the event register, evaluated from
// there, and its response is registered in the response register.
// Throughput: one event per cycle while rsp_tready is high; the state update
// for one event is a single level of compare-and-select logic between the event
// register and the state/response registers, so the next event sees it right away.
// Reset (synchronous): state goes to wifi connect, target, tick count and
// error clear, registers take their power-on values, both channels empty.
// Stall: while rsp_tready is low the response is held; one more event is
// buffered in the event register, then req_tready drops.
`default_nettype none

module stop_block_motion_sequencer (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [20:0] motion_value, [21] cut_available, [22] tool_present,
   // [38:23] kerf, [39] stepper_moving, [40] far_switch,
   // [42:41] homing_phase, [44:43] latch_status, [45] dust_spun_up,
   // [46] wifi_connected, [67:47] dro_position, [71:68] zero
   input  wire logic [71:0] req_tdata,
   // [3:0] mode
   input  wire logic [3:0]  req_tuser,
   // Response
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [3:0] fsm_state_out, [6:4] light_pattern, [9:7] stepper_cmd,
   // [30:10] stepper_value, [32:31] latch_cmd, [34:33] dust_cmd,
   // [36:35] clamp_cmd, [38:37] wifi_cmd, [39] mark_cut_done,
   // [42:40] error_code, [62:43] target_position, [63] zero
   output logic [63:0]      rsp_tdata,
   // Configuration
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [23:0] csr_wdata
);

   sbms_pkg::cfg_type    cfg;
   sbms_pkg::item_type   item_ff;
   sbms_pkg::item_type   item_in;
   logic                 item_valid_ff;
   logic                 item_valid_in;
   sbms_pkg::ctx_type    ctx_ff;
   sbms_pkg::ctx_type    ctx_in;
   sbms_pkg::ctx_type    ctx_next;
   sbms_pkg::result_type rsp_ff;
   sbms_pkg::result_type rsp_in;
   sbms_pkg::result_type rsp_next;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 req_take;
   logic                 fire;

   sbms_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sbms_step u_step (
      .cur  (ctx_ff),
      .cfg  (cfg),
      .item (item_ff),
      .nxt  (ctx_next),
      .rsp  (rsp_next)
   );

   // Evaluate the buffered event whenever the response register can take it.
   assign fire       = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || fire;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      item_in = item_ff;
      if (req_take) begin
         item_in.mode           = req_tuser;
         item_in.motion_value   = $signed(req_tdata[20:0]);
         item_in.cut_available  = req_tdata[21];
         item_in.tool_present   = req_tdata[22];
         item_in.kerf           = req_tdata[38:23];
         item_in.stepper_moving = req_tdata[39];
         item_in.far_switch     = req_tdata[40];
         item_in.homing_phase   = req_tdata[42:41];
         item_in.latch_status   = req_tdata[44:43];
         item_in.dust_spun_up   = req_tdata[45];
         item_in.wifi_connected = req_tdata[46];
         item_in.dro_position   = $signed(req_tdata[67:47]);
      end
      item_valid_in = req_take ? 1'b1 : (fire ? 1'b0 : item_valid_ff);

      ctx_in = fire ? ctx_next : ctx_ff;
      rsp_in = fire ? rsp_next : rsp_ff;
      rsp_valid_in = fire ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff       <= 1'b0;
         rsp_valid_ff        <= 1'b0;
         ctx_ff.fsm_state      <= sbms_pkg::ST_WIFI;
         ctx_ff.target_reg     <= '0;
         ctx_ff.ticks_in_state <= '0;
         ctx_ff.wifi_started   <= 1'b0;
         ctx_ff.last_error     <= sbms_pkg::ERR_NONE;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         ctx_ff        <= ctx_in;
      end
   end

   // Payload registers: no reset.
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0,
                        rsp_ff.target_position,
                        rsp_ff.error_code,
                        rsp_ff.mark_cut_done,
                        rsp_ff.wifi_cmd,
                        rsp_ff.clamp_cmd,
                        rsp_ff.dust_cmd,
                        rsp_ff.latch_cmd,
                        rsp_ff.stepper_value,
                        rsp_ff.stepper_cmd,
                        rsp_ff.light_pattern,
                        rsp_ff.fsm_state_out};

   // An e-stop event always lands in the e-stop state.
   a_estop_wins: assert property (@(posedge clock) disable iff (reset)
      fire && item_ff.mode == sbms_pkg::MODE_ESTOP |=> ctx_ff.fsm_state == sbms_pkg::ST_ESTOP)
      else $error("e-stop event did not reach e-stop state");

   // A latched error only lives in the error or e-stop state.
   a_error_state: assert property (@(posedge clock) disable iff (reset)
      ctx_ff.last_error != sbms_pkg::ERR_NONE |->
         ctx_ff.fsm_state == sbms_pkg::ST_ERROR || ctx_ff.fsm_state == sbms_pkg::ST_ESTOP)
      else $error("error code latched outside error states");

   // Every transition restarts the tick count.
   a_ticks_clear: assert property (@(posedge clock) disable iff (reset)
      fire && ctx_next.fsm_state != ctx_ff.fsm_state |=> ctx_ff.ticks_in_state == '0)
      else $error("tick count not cleared on state entry");

   // Back-pressure only when both the event and response registers are full.
   a_ready_low: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> item_valid_ff && rsp_valid_ff && !rsp_tready)
      else $error("request stalled with room available");

endmodule

`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

   // Sequencer state codes as they appear on the response word.
   typedef enum logic [3:0] {
      SQ_BOOT, SQ_WIFI, SQ_NEEDS_HOMING, SQ_HOMING, SQ_IDLE, SQ_UNLOCKING,
      SQ_MOVING, SQ_SETTLING, SQ_LOCKING, SQ_LOCKED, SQ_DUST, SQ_CUTTING,
      SQ_ERROR, SQ_ESTOP
   } seq_state_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;   // motion_value, cut_available, tool_present, kerf,
                             // stepper_moving, far_switch, homing_phase,
                             // latch_status, dust_spun_up, wifi_connected,
                             // dro_position, zero fill
   logic [3:0]  req_tuser;   // mode
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;   // fsm_state_out, light_pattern, stepper_cmd,
                             // stepper_value, latch_cmd, dust_cmd, clamp_cmd,
                             // wifi_cmd, mark_cut_done, error_code,
                             // target_position, zero fill
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [23:0] csr_wdata;

   stop_block_motion_sequencer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Mirror of the sequencer: state, held target, tick count, station flag,
   // latched error and the register settings.
   seq_state_type        cur_state;
   logic [19:0]          held_target;
   logic [23:0]          state_ticks;
   logic                 station_started;
   logic [2:0]           held_error;
   sbms_pkg::cfg_type    settings;
   sbms_pkg::result_type step_out;

   sbms_pkg::result_type pending_results[$];
   int          words_sent;
   int          responses_checked;
   int          error_count;
   int          cuts_marked;
   logic [15:0] seen_states;
   logic        quiet;
   int unsigned stall_left;

   always #2 clock = ~clock;

   // Hard stop in case the block hangs.
   initial begin
      #2ms;
      $display("simulation failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------
   function automatic void enter(input seq_state_type s);
      cur_state   = s;
      state_ticks = '0;
   endfunction

   // Go-to: only from idle or locked, and only inside [0, max_travel].
   function automatic void try_goto(input int aim);
      if (cur_state != SQ_IDLE && cur_state != SQ_LOCKED) return;
      if (aim < 0 || aim > int'(settings.max_travel)) return;
      held_target = aim[19:0];
      if (cur_state == SQ_LOCKED) begin
         step_out.latch_cmd = sbms_pkg::LATCH_UNLOCK;
         enter(SQ_UNLOCKING);
      end else begin
         step_out.stepper_cmd   = sbms_pkg::STEP_MOVE;
         step_out.stepper_value = {1'b0, held_target};
         enter(SQ_MOVING);
      end
   endfunction

   function automatic sbms_pkg::result_type advance_sequencer(input sbms_pkg::item_type w);
      int mv;
      int miss;
      step_out = '0;
      mv = {{11{w.motion_value[20]}}, w.motion_value};
      case (w.mode)
         sbms_pkg::MODE_TICK: begin
            if (state_ticks != sbms_pkg::TICK_MAX) state_ticks = state_ticks + 1'b1;
            case (cur_state)
               SQ_WIFI: begin
                  // Station start goes out once per stay; fallback overrides it.
                  if (!station_started) begin
                     step_out.wifi_cmd = sbms_pkg::WIFI_STATION;
                     station_started = 1'b1;
                  end
                  if (w.wifi_connected) begin
                     station_started = 1'b0;
                     enter(SQ_NEEDS_HOMING);
                  end else if (state_ticks > settings.wifi_timeout_ticks &&
                               settings.ap_fallback_enable) begin
                     step_out.wifi_cmd = sbms_pkg::WIFI_AP;
                     station_started = 1'b0;
                     enter(SQ_NEEDS_HOMING);
                  end
               end
               SQ_HOMING: begin
                  if (w.homing_phase == sbms_pkg::PHASE_DONE) enter(SQ_IDLE);
                  else if (w.homing_phase == sbms_pkg::PHASE_FAIL) begin
                     held_error = sbms_pkg::ERR_HOMING;
                     enter(SQ_ERROR);
                  end
               end
               SQ_UNLOCKING: begin
                  if (w.latch_status == sbms_pkg::LSTAT_UNLOCKED) begin
                     if (held_target != '0) begin
                        step_out.stepper_cmd   = sbms_pkg::STEP_MOVE;
                        step_out.stepper_value = {1'b0, held_target};
                        enter(SQ_MOVING);
                     end else begin
                        enter(SQ_IDLE);
                     end
                  end
               end
               SQ_MOVING: begin
                  if (!w.stepper_moving) enter(SQ_SETTLING);
                  if (cur_state == SQ_MOVING &&
                      state_ticks > settings.move_timeout_ticks) begin
                     step_out.stepper_cmd   = sbms_pkg::STEP_STOP;
                     step_out.stepper_value = '0;
                     held_error = sbms_pkg::ERR_TIMEOUT;
                     enter(SQ_ERROR);
                  end
               end
               SQ_SETTLING: begin
                  miss = {{11{w.dro_position[20]}}, w.dro_position} - int'(held_target);
                  if (miss < 0) miss = -miss;
                  if (miss <= int'(settings.position_tolerance)) begin
                     step_out.latch_cmd = sbms_pkg::LATCH_LOCK;
                     enter(SQ_LOCKING);
                  end else if (state_ticks > settings.settling_timeout_ticks) begin
                     held_error = sbms_pkg::ERR_POS;
                     enter(SQ_ERROR);
                  end
               end
               SQ_LOCKING: if (w.latch_status == sbms_pkg::LSTAT_LOCKED) enter(SQ_LOCKED);
               SQ_DUST:    if (w.dust_spun_up) enter(SQ_CUTTING);
               default: ;
            endcase
            // Far limit applies only when the carriage is still moving.
            if (cur_state == SQ_MOVING && w.far_switch) begin
               step_out.stepper_cmd   = sbms_pkg::STEP_STOP;
               step_out.stepper_value = '0;
               held_error = sbms_pkg::ERR_FAR;
               enter(SQ_ERROR);
            end
         end
         sbms_pkg::MODE_HOME: begin
            if (cur_state == SQ_NEEDS_HOMING || cur_state == SQ_IDLE) begin
               step_out.stepper_cmd = sbms_pkg::STEP_HOME;
               enter(SQ_HOMING);
            end
         end
         sbms_pkg::MODE_GOTO: try_goto(mv);
         sbms_pkg::MODE_LOCK, sbms_pkg::MODE_UNLOCK, sbms_pkg::MODE_LOCK_TOGGLE: begin
            if (cur_state == SQ_IDLE && w.mode != sbms_pkg::MODE_UNLOCK) begin
               step_out.latch_cmd = sbms_pkg::LATCH_LOCK;
               enter(SQ_LOCKING);
            end else if (cur_state == SQ_LOCKED && w.mode != sbms_pkg::MODE_LOCK) begin
               step_out.latch_cmd = sbms_pkg::LATCH_UNLOCK;
               step_out.clamp_cmd = sbms_pkg::CLAMP_RELEASE;
               enter(SQ_UNLOCKING);
            end
         end
         sbms_pkg::MODE_ESTOP: begin
            step_out.stepper_cmd = sbms_pkg::STEP_ESTOP;
            step_out.dust_cmd    = sbms_pkg::DUST_FORCE;
            step_out.clamp_cmd   = sbms_pkg::CLAMP_RELEASE;
            enter(SQ_ESTOP);
         end
         sbms_pkg::MODE_RESET: begin
            if (cur_state == SQ_ERROR || cur_state == SQ_ESTOP) begin
               held_error = sbms_pkg::ERR_NONE;
               enter(SQ_NEEDS_HOMING);
            end
         end
         sbms_pkg::MODE_START_CUT: begin
            if (cur_state == SQ_LOCKED) begin
               step_out.dust_cmd  = sbms_pkg::DUST_ON;
               step_out.clamp_cmd = sbms_pkg::CLAMP_ENGAGE;
               enter(SQ_DUST);
            end
         end
         sbms_pkg::MODE_END_CUT: begin
            if (cur_state == SQ_CUTTING) begin
               step_out.dust_cmd      = sbms_pkg::DUST_OFF;
               step_out.clamp_cmd     = sbms_pkg::CLAMP_RELEASE;
               step_out.mark_cut_done = w.cut_available;
               enter(SQ_LOCKED);
            end
         end
         sbms_pkg::MODE_JOG: begin
            if (cur_state == SQ_IDLE) begin
               step_out.stepper_cmd   = sbms_pkg::STEP_JOG;
               step_out.stepper_value = w.motion_value;
               enter(SQ_MOVING);
            end
         end
         sbms_pkg::MODE_NEXT_CUT: begin
            if ((cur_state == SQ_IDLE || cur_state == SQ_LOCKED) && w.cut_available)
               try_goto(mv + (w.tool_present ? int'(w.kerf) : 0));
         end
         default: ;
      endcase

      step_out.fsm_state_out = cur_state;
      case (cur_state)
         SQ_NEEDS_HOMING, SQ_MOVING:
            step_out.light_pattern = sbms_pkg::LIGHT_PULSE_YELLOW;
         SQ_HOMING:
            step_out.light_pattern = sbms_pkg::LIGHT_BLUE;
         SQ_IDLE, SQ_LOCKED:
            step_out.light_pattern = sbms_pkg::LIGHT_GREEN;
         SQ_UNLOCKING, SQ_SETTLING, SQ_LOCKING:
            step_out.light_pattern = sbms_pkg::LIGHT_PULSE_GREEN;
         SQ_DUST, SQ_CUTTING:
            step_out.light_pattern = sbms_pkg::LIGHT_ORANGE;
         SQ_ERROR:
            step_out.light_pattern = sbms_pkg::LIGHT_RED;
         SQ_ESTOP:
            step_out.light_pattern = sbms_pkg::LIGHT_FLASH_RED;
         default:
            step_out.light_pattern = sbms_pkg::LIGHT_CHASE_WHITE;
      endcase
      step_out.error_code      = held_error;
      step_out.target_position = held_target;
      seen_states[cur_state]   = 1'b1;
      if (step_out.mark_cut_done) cuts_marked++;
      return step_out;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   // Every field random; callers pin the ones that matter.
   function automatic sbms_pkg::item_type random_word(input logic [3:0] m);
      sbms_pkg::item_type w;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      a = $urandom;
      b = $urandom;
      c = $urandom;
      w.mode           = m;
      w.motion_value   = a[20:0];
      w.cut_available  = a[21];
      w.tool_present   = a[22];
      w.stepper_moving = a[23];
      w.far_switch     = a[24];
      w.homing_phase   = a[26:25];
      w.latch_status   = a[28:27];
      w.dust_spun_up   = a[29];
      w.wifi_connected = a[30];
      w.kerf           = b[15:0];
      w.dro_position   = c[20:0];
      return w;
   endfunction

   // Go-to target biased toward the edges of the accepted range.
   function automatic int pick_target();
      int unsigned sel;
      int          t;
      sel = $urandom_range(0, 11);
      case (sel)
         0:       t = -int'($urandom_range(1, 1048576));
         1:       t = int'(settings.max_travel) + 1;
         2:       t = int'(settings.max_travel);
         3:       t = 0;
         default: t = int'($urandom_range(0, settings.max_travel));
      endcase
      return t;
   endfunction

   // Pick an event that pushes the sequencer forward from where it is now;
   // a small share is e-stop or plain noise.
   function automatic sbms_pkg::item_type next_step_word();
      sbms_pkg::item_type w;
      int          aim;
      int unsigned pick;
      logic [31:0] bits;
      w = random_word(sbms_pkg::MODE_TICK);
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         w.mode = sbms_pkg::MODE_ESTOP;
         return w;
      end
      if (pick < 11) begin
         bits = $urandom;
         w.mode = bits[3:0];
         return w;
      end
      pick = $urandom_range(0, 9);
      case (cur_state)
         SQ_NEEDS_HOMING: if (pick < 8) w.mode = sbms_pkg::MODE_HOME;
         SQ_HOMING: begin
            if (pick < 2)       w.homing_phase = sbms_pkg::PHASE_RUNNING;
            else if (pick == 2) w.homing_phase = 2'd3;
            else if (pick == 3) w.homing_phase = sbms_pkg::PHASE_FAIL;
            else                w.homing_phase = sbms_pkg::PHASE_DONE;
         end
         SQ_IDLE, SQ_LOCKED: begin
            if (cur_state == SQ_LOCKED && pick < 4) begin
               w.mode = sbms_pkg::MODE_START_CUT;
            end else if (cur_state == SQ_IDLE && pick == 3) begin
               w.mode = sbms_pkg::MODE_JOG;
               aim = int'($urandom_range(0, 10000)) - 5000;
               w.motion_value = aim[20:0];
            end else begin
               case (pick)
                  0, 1, 2, 4: begin
                     w.mode = sbms_pkg::MODE_GOTO;
                     aim = pick_target();
                     w.motion_value = aim[20:0];
                  end
                  5: begin
                     w.mode = sbms_pkg::MODE_NEXT_CUT;
                     w.cut_available = ($urandom_range(0, 5) != 0);
                     aim = pick_target() - (w.tool_present ? int'(w.kerf) : 0);
                     w.motion_value = aim[20:0];
                  end
                  6:       w.mode = sbms_pkg::MODE_LOCK_TOGGLE;
                  7:       w.mode = sbms_pkg::MODE_LOCK;
                  8:       w.mode = sbms_pkg::MODE_UNLOCK;
                  default: w.mode = sbms_pkg::MODE_HOME;
               endcase
            end
         end
         SQ_UNLOCKING: if (pick < 6) w.latch_status = sbms_pkg::LSTAT_UNLOCKED;
         SQ_MOVING: begin
            w.stepper_moving = (pick < 6);
            w.far_switch     = ($urandom_range(0, 24) == 0);
         end
         SQ_SETTLING: begin
            // Land near the target, inside and just outside the window.
            if (pick >= 2) begin
               aim = int'(held_target) - int'(settings.position_tolerance) - 2 +
                     int'($urandom_range(0, 2 * settings.position_tolerance + 4));
               w.dro_position = aim[20:0];
            end
         end
         SQ_LOCKING: if (pick < 6) w.latch_status = sbms_pkg::LSTAT_LOCKED;
         SQ_DUST:    w.dust_spun_up = (pick < 5);
         SQ_CUTTING: if (pick < 7) w.mode = sbms_pkg::MODE_END_CUT;
         SQ_ERROR, SQ_ESTOP: if (pick < 7) w.mode = sbms_pkg::MODE_RESET;
         default: ;
      endcase
      return w;
   endfunction

   function automatic int unsigned draw_gap();
      if (quiet || $urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 16);
   endfunction

   function automatic sbms_pkg::cfg_type make_settings(input logic [19:0] travel,
                                                       input logic [15:0] tol,
                                                       input logic [23:0] move_to,
                                                       input logic [23:0] settle_to,
                                                       input logic [23:0] wifi_to,
                                                       input logic        fallback);
      sbms_pkg::cfg_type c;
      c.max_travel             = travel;
      c.position_tolerance     = tol;
      c.move_timeout_ticks     = move_to;
      c.settling_timeout_ticks = settle_to;
      c.wifi_timeout_ticks     = wifi_to;
      c.ap_fallback_enable     = fallback;
      return c;
   endfunction

   // Send one event word: idle a random while, hold it until taken,
   // then log its expected response.
   task automatic send_word(input sbms_pkg::item_type w);
      int unsigned gap;
      gap = draw_gap();
      if ($urandom_range(0, 49) == 0) quiet = !quiet;
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser  = w.mode;
      req_tdata  = {4'b0, w.dro_position, w.wifi_connected, w.dust_spun_up,
                    w.latch_status, w.homing_phase, w.far_switch,
                    w.stepper_moving, w.kerf, w.tool_present, w.cut_available,
                    w.motion_value};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(advance_sequencer(w));
      words_sent++;
   endtask

   // Drop valid and let every outstanding response come back, plus the
   // pipeline depth, so a register write lands on an idle block.
   task automatic wait_for_drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_setting(input logic [2:0] idx, input logic [23:0] val);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we    = 1'b0;
      case (idx)
         sbms_pkg::CSR_MAX_TRAVEL:     settings.max_travel             = val[19:0];
         sbms_pkg::CSR_POS_TOL:        settings.position_tolerance     = val[15:0];
         sbms_pkg::CSR_MOVE_TIMEOUT:   settings.move_timeout_ticks     = val;
         sbms_pkg::CSR_SETTLE_TIMEOUT: settings.settling_timeout_ticks = val;
         sbms_pkg::CSR_WIFI_TIMEOUT:   settings.wifi_timeout_ticks     = val;
         sbms_pkg::CSR_AP_FALLBACK:    settings.ap_fallback_enable     = val[0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input sbms_pkg::cfg_type c);
      write_setting(sbms_pkg::CSR_MAX_TRAVEL,     {4'b0, c.max_travel});
      write_setting(sbms_pkg::CSR_POS_TOL,        {8'b0, c.position_tolerance});
      write_setting(sbms_pkg::CSR_MOVE_TIMEOUT,   c.move_timeout_ticks);
      write_setting(sbms_pkg::CSR_SETTLE_TIMEOUT, c.settling_timeout_ticks);
      write_setting(sbms_pkg::CSR_WIFI_TIMEOUT,   c.wifi_timeout_ticks);
      write_setting(sbms_pkg::CSR_AP_FALLBACK,    {23'b0, c.ap_fallback_enable});
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   // Wifi connect is only visited once per run, so pick one of its exits:
   // link up, fallback after it was held off, or fallback on the first tick
   // overriding the station start.
   task automatic test_station_startup();
      sbms_pkg::item_type w;
      int unsigned variant;
      variant = $urandom_range(0, 2);
      if (variant != 0) begin
         write_setting(sbms_pkg::CSR_WIFI_TIMEOUT, 24'd0);
         write_setting(sbms_pkg::CSR_AP_FALLBACK, {23'b0, (variant == 2)});
      end
      w = random_word(sbms_pkg::MODE_TICK);
      w.wifi_connected = 1'b0;
      send_word(w);
      if (variant == 1) begin
         send_word(w);
         wait_for_drain();
         write_setting(sbms_pkg::CSR_AP_FALLBACK, 24'd1);
         send_word(w);
      end else if (variant == 0) begin
         send_word(w);
         w.wifi_connected = 1'b1;
         send_word(w);
      end
   endtask

   // Walk the main paths by hand: rejected and unused commands, homing
   // results, go-to range edges, next cut with kerf, far limit, e-stop.
   task automatic test_command_walk();
      sbms_pkg::item_type w;
      w = random_word(sbms_pkg::MODE_GOTO);  w.motion_value = 21'd100;  send_word(w);
      w = random_word(4'd12);                send_word(w);
      w = random_word(4'd15);                send_word(w);
      w = random_word(sbms_pkg::MODE_HOME);  send_word(w);
      w = random_word(sbms_pkg::MODE_TICK);
      w.homing_phase = sbms_pkg::PHASE_RUNNING;
      send_word(w);
      w = random_word(sbms_pkg::MODE_TICK);  w.homing_phase = 2'd3;  send_word(w);
      w = random_word(sbms_pkg::MODE_TICK);
      w.homing_phase = sbms_pkg::PHASE_DONE;
      send_word(w);
      w = random_word(sbms_pkg::MODE_GOTO);  w.motion_value = -21'sd1;  send_word(w);
      w = random_word(sbms_pkg::MODE_GOTO);  w.motion_value = 21'd120001; send_word(w);
      w = random_word(sbms_pkg::MODE_LOCK);  send_word(w);
      w = random_word(sbms_pkg::MODE_TICK);
      w.latch_status = sbms_pkg::LSTAT_TRANSIT;
      send_word(w);
      w = random_word(sbms_pkg::MODE_TICK);  w.latch_status = 2'd3;  send_word(w);
      w = random_word(sbms_pkg::MODE_TICK);
      w.latch_status = sbms_pkg::LSTAT_LOCKED;
      send_word(w);
      w = random_word(sbms_pkg::MODE_NEXT_CUT);
      w.cut_available = 1'b0;
      send_word(w);
      // Length plus kerf lands exactly on max travel.
      w = random_word(sbms_pkg::MODE_NEXT_CUT);
      w.cut_available = 1'b1;
      w.tool_present  = 1'b1;
      w.kerf          = 16'd317;
      w.motion_value  = 21'd119683;
      send_word(w);
      w = random_word(sbms_pkg::MODE_TICK);
      w.latch_status = sbms_pkg::LSTAT_UNLOCKED;
      w.far_switch   = 1'b0;
      send_word(w);
      w = random_word(sbms_pkg::MODE_TICK);
      w.stepper_moving = 1'b1;
      w.far_switch     = 1'b1;
      send_word(w);
      w = random_word(sbms_pkg::MODE_JOG);   send_word(w);
      w = random_word(sbms_pkg::MODE_RESET); send_word(w);
      w = random_word(sbms_pkg::MODE_HOME);  send_word(w);
      w = random_word(sbms_pkg::MODE_TICK);
      w.homing_phase = sbms_pkg::PHASE_FAIL;
      send_word(w);
      w = random_word(sbms_pkg::MODE_ESTOP); send_word(w);
      w = random_word(sbms_pkg::MODE_RESET); send_word(w);
      w = random_word(sbms_pkg::MODE_HOME);  send_word(w);
      w = random_word(sbms_pkg::MODE_TICK);
      w.homing_phase = sbms_pkg::PHASE_DONE;
      send_word(w);
      w = random_word(sbms_pkg::MODE_JOG);   w.motion_value = 21'h100000; send_word(w);
   endtask

   // One register setting, then a long run of mostly well-formed cycles.
   task automatic test_cut_cycles(input sbms_pkg::cfg_type c, input int words);
      wait_for_drain();
      apply_settings(c);
      repeat (words) send_word(next_step_word());
   endtask

   // ------------------------------------------------------------------
   // Response side: random stalls, and check every word taken.
   // ------------------------------------------------------------------
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left != 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t ns: %s expected 'h%0h, got 'h%0h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin : check_response
      sbms_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         stall_left = draw_gap();
         if (pending_results.size() == 0) begin
            error_count++;
            $display("%0t ns: response word 'h%0h with no event outstanding",
                     $time, rsp_tdata);
         end else begin
            want = pending_results.pop_front();
            responses_checked++;
            compare_field("fsm_state_out",   32'(want.fsm_state_out),
                          32'(rsp_tdata[3:0]));
            compare_field("light_pattern",   32'(want.light_pattern),
                          32'(rsp_tdata[6:4]));
            compare_field("stepper_cmd",     32'(want.stepper_cmd),
                          32'(rsp_tdata[9:7]));
            compare_field("stepper_value",   32'($unsigned(want.stepper_value)),
                          32'(rsp_tdata[30:10]));
            compare_field("latch_cmd",       32'(want.latch_cmd),
                          32'(rsp_tdata[32:31]));
            compare_field("dust_cmd",        32'(want.dust_cmd),
                          32'(rsp_tdata[34:33]));
            compare_field("clamp_cmd",       32'(want.clamp_cmd),
                          32'(rsp_tdata[36:35]));
            compare_field("wifi_cmd",        32'(want.wifi_cmd),
                          32'(rsp_tdata[38:37]));
            compare_field("mark_cut_done",   32'(want.mark_cut_done),
                          32'(rsp_tdata[39]));
            compare_field("error_code",      32'(want.error_code),
                          32'(rsp_tdata[42:40]));
            compare_field("target_position", 32'(want.target_position),
                          32'(rsp_tdata[62:43]));
         end
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      logic [31:0] a;
      logic [31:0] b;
      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      quiet      = 1'b0;
      stall_left = 0;
      words_sent = 0;
      responses_checked = 0;
      error_count = 0;
      cuts_marked = 0;
      seen_states = '0;

      // Power-on view of the sequencer.
      cur_state       = SQ_WIFI;
      held_target     = '0;
      state_ticks     = '0;
      station_started = 1'b0;
      held_error      = sbms_pkg::ERR_NONE;
      settings = make_settings(20'd120000, 16'd5, 24'd30000, 24'd2000, 24'd10000, 1'b1);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_station_startup();
      test_command_walk();
      // Short timeouts so move and settle failures show up.
      test_cut_cycles(make_settings(20'd120000, 16'd5, 24'd6, 24'd4, 24'd10000, 1'b1), 300);
      // Everything at zero.
      test_cut_cycles(make_settings('0, '0, '0, '0, '0, 1'b0), 300);
      // Everything at full scale.
      test_cut_cycles(make_settings(20'hFFFFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF,
                                    24'hFFFFFF, 1'b1), 300);
      repeat (2) begin
         a = $urandom;
         b = $urandom;
         test_cut_cycles(make_settings(a[19:0], {8'b0, b[7:0]}, {19'b0, b[12:8]},
                                       {19'b0, b[17:13]}, {8'b0, a[31:16]},
                                       b[18]), 300);
      end
      wait_for_drain();

      $display("%0d event words sent, %0d responses checked, %0d cut completions",
               words_sent, responses_checked, cuts_marked);
      $display("%0d of 13 sequencer states reached", $countones(seen_states));
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/sbms_pkg.sv
rtl/core/sbms_csr.sv
rtl/core/sbms_step.sv
rtl/core/stop_block_motion_sequencer.sv
bench/testbench.sv
